@@ rtl/core/srfm_pkg.sv @@
// ----------------------------------------------------------------------------
// srfm_pkg
// shared constants and types for the pulse ratio frequency meter
// ----------------------------------------------------------------------------
`default_nettype none

package srfm_pkg;

   localparam int TIME_WIDTH_DEFAULT = 32;

   // width of the reported period and of the divisor path
   localparam int PERIOD_W = 32;
   // width of ticks_per_second * 1000, also the quotient width
   localparam int NUM_W    = 30;
   localparam int FREQ_W   = 30;
   localparam int STRETCH_W = 16;
   localparam int TPS_W    = 20;
   localparam int SCALE_W  = 10;

   localparam logic [STRETCH_W-1:0] STRETCH_RESET = 16'd10;
   localparam logic [TPS_W-1:0]     TPS_RESET     = 20'd1000;
   localparam logic [SCALE_W-1:0]   FREQ_SCALE    = 10'd1000;
   localparam logic [FREQ_W-1:0]    FREQ_MAX      = 30'd1000000000;
   localparam logic [63:0]          PREV_RESET    = 64'd999999;

   // configuration register index, taken from the word address
   localparam logic REG_STRETCH = 1'b0;
   localparam logic REG_TPS     = 1'b1;

   // one-hot phase strobes from the sequencer to the timing unit
   typedef struct packed {
      logic capture;
      logic ratio;
      logic fire;
   } phase_type;

   // marker result from the timing unit
   typedef struct packed {
      logic                fired;
      logic                level;
      logic [PERIOD_W-1:0] period;
      logic                period_big;
   } mark_type;

   // divider launch
   typedef struct packed {
      logic                start;
      logic [NUM_W-1:0]    numerator;
      logic [PERIOD_W-1:0] divisor;
      logic                divisor_big;
   } div_req_type;

endpackage

`default_nettype wire

@@ rtl/core/sync_pulse_ratio_frequency_meter.sv @@
// ----------------------------------------------------------------------------
// sync_pulse_ratio_frequency_meter
// pulse width ratio marker detector with millihertz frequency readout
// ----------------------------------------------------------------------------
// Each req transaction is one tick carrying the sampled pin level in
// req_tdata[0]; each one yields exactly one rsp transaction. A tick without a
// marker goes from acceptance to the result register through capture, ratio
// test, marker/release, launch and load. A tick that fires a marker also
// runs the bit-serial divider for ticks_per_second*1000 / period between
// launch and load, one quotient bit per cycle.
// One tick is worked on at a time; the next one is accepted as soon as the
// current result sits in the output register, even if rsp is stalled.
// Registers (write at psel & penable & pwrite): byte 0 stretch_ticks
// (16 bit), byte 4 ticks_per_second (20 bit). Write them only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_pulse_ratio_frequency_meter #(
   parameter int TIME_WIDTH = srfm_pkg::TIME_WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,

   // tick input: [0] signal_level, [7:1] zero
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,

   // result: [0] out_level, [32:1] marker_period, [62:33] frequency_mhz,
   // [63] period_zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,
   // result kind: [0] marker_seen
   output logic             rsp_tuser,

   // configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import srfm_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_RATIO  = 6'b000010,
      ST_FIRE   = 6'b000100,
      ST_LAUNCH = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [STRETCH_W-1:0] stretch_ff;
   logic [TPS_W-1:0]     tps_ff;
   logic                 csr_write;
   logic                 csr_index;

   // datapath links
   phase_type            phase;
   mark_type             mark;
   div_req_type          div_req;
   logic                 div_busy;
   logic [NUM_W-1:0]     quotient;

   // output register
   logic                 rsp_valid_ff;
   logic [63:0]          rsp_data_ff, rsp_data_in;
   logic                 rsp_user_ff;
   logic                 in_accept;
   logic                 out_load;
   logic [FREQ_W-1:0]    freq_sat;
   logic                 period_zero;

   // ---------------------------------------------------------------------
   // configuration port, word decode on the address bit above the byte lane
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stretch_ff <= STRETCH_RESET;
         tps_ff     <= TPS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_STRETCH: stretch_ff <= csr_pwdata[STRETCH_W-1:0];
            REG_TPS:     tps_ff     <= csr_pwdata[TPS_W-1:0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_STRETCH: csr_prdata = 32'(stretch_ff);
         REG_TPS:     csr_prdata = 32'(tps_ff);
         default:     csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // sequencer: one tick walks capture -> ratio -> fire -> launch
   // (-> divide when a marker fired) -> emit into the output register
   // ---------------------------------------------------------------------
   assign req_tready = (state_ff == ST_IDLE);
   assign in_accept  = req_tvalid && req_tready;
   assign out_load   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (in_accept) state_in = ST_RATIO;
         ST_RATIO:  state_in = ST_FIRE;
         ST_FIRE:   state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = mark.fired ? ST_DIV : ST_EMIT;
         ST_DIV:    if (!div_busy) state_in = ST_EMIT;
         ST_EMIT:   if (out_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign phase.capture = in_accept;
   assign phase.ratio   = (state_ff == ST_RATIO);
   assign phase.fire    = (state_ff == ST_FIRE);

   srfm_timing #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_timing (
      .clock         (clock),
      .reset         (reset),
      .phase         (phase),
      .signal_level  (req_tdata[0]),
      .stretch_ticks (stretch_ff),
      .mark          (mark)
   );

   // numerator ticks_per_second * 1000 fits in 30 bits for any 20-bit rate;
   // a zero divisor gives an all-ones quotient, which saturates below
   assign div_req.start       = (state_ff == ST_LAUNCH) && mark.fired;
   assign div_req.numerator   = NUM_W'(tps_ff) * NUM_W'(FREQ_SCALE);
   assign div_req.divisor     = mark.period;
   assign div_req.divisor_big = mark.period_big;

   srfm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // ---------------------------------------------------------------------
   // result formatting and output register
   // ---------------------------------------------------------------------
   assign period_zero = mark.fired && !mark.period_big && (mark.period == '0);
   assign freq_sat    = (FREQ_W'(quotient) > FREQ_MAX) ? FREQ_MAX : FREQ_W'(quotient);

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[0] = mark.level;
      if (mark.fired) begin
         rsp_data_in[32:1]  = mark.period;
         rsp_data_in[62:33] = freq_sat;
         rsp_data_in[63]    = period_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= mark.fired;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

@@ rtl/core/srfm_timing.sv @@
// ----------------------------------------------------------------------------
// srfm_timing
// tick counter, edge timing, width ratio test and output stretch
// ----------------------------------------------------------------------------
`default_nettype none

module srfm_timing #(
   parameter int TIME_WIDTH = srfm_pkg::TIME_WIDTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire srfm_pkg::phase_type                phase,
   input  wire logic                               signal_level,
   input  wire logic [srfm_pkg::STRETCH_W-1:0]     stretch_ticks,
   output srfm_pkg::mark_type                      mark
);
   import srfm_pkg::*;

   logic [TIME_WIDTH-1:0] tick_count_ff, tick_count_in;
   logic                  waiting_ff, waiting_in;
   logic [TIME_WIDTH-1:0] rise_time_ff, rise_time_in;
   logic [TIME_WIDTH-1:0] width_ff, width_in;
   logic [TIME_WIDTH-1:0] prev_ff, prev_in;
   logic                  pending_ff, pending_in;
   logic                  fall_ff, fall_in;
   logic                  active_ff, active_in;
   logic [TIME_WIDTH-1:0] start_ff, start_in;
   logic [TIME_WIDTH-1:0] last_rise_ff, last_rise_in;
   logic [TIME_WIDTH-1:0] period_ff, period_in;
   logic                  fired_ff, fired_in;

   logic                  ratio_hit;
   logic [TIME_WIDTH-1:0] held_ticks;

   // width / prev >= 2 is width >= 2*prev
   assign ratio_hit  = (prev_ff == '0) || ({1'b0, width_ff} >= {prev_ff, 1'b0});
   assign held_ticks = tick_count_ff - start_ff;

   always_comb begin
      tick_count_in = tick_count_ff;
      waiting_in    = waiting_ff;
      rise_time_in  = rise_time_ff;
      width_in      = width_ff;
      prev_in       = prev_ff;
      pending_in    = pending_ff;
      fall_in       = fall_ff;
      active_in     = active_ff;
      start_in      = start_ff;
      last_rise_in  = last_rise_ff;
      period_in     = period_ff;
      fired_in      = fired_ff;

      if (phase.capture) begin
         fall_in = !signal_level && !waiting_ff;
         if (signal_level && waiting_ff) begin
            rise_time_in = tick_count_ff;
            waiting_in   = 1'b0;
         end
         if (!signal_level && !waiting_ff) begin
            width_in   = tick_count_ff - rise_time_ff;
            waiting_in = 1'b1;
         end
      end

      if (phase.ratio && fall_ff) begin
         pending_in = ratio_hit;
         prev_in    = width_ff;
      end

      if (phase.fire) begin
         tick_count_in = tick_count_ff + 1'b1;
         if (pending_ff && !active_ff) begin
            active_in    = 1'b1;
            start_in     = tick_count_ff;
            pending_in   = 1'b0;
            prev_in      = width_ff;
            period_in    = rise_time_ff - last_rise_ff;
            last_rise_in = rise_time_ff;
            fired_in     = 1'b1;
         end else begin
            fired_in = 1'b0;
            if (active_ff && (held_ticks > TIME_WIDTH'(stretch_ticks))) begin
               active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         waiting_ff    <= 1'b1;
         rise_time_ff  <= '0;
         width_ff      <= '0;
         prev_ff       <= TIME_WIDTH'(PREV_RESET);
         pending_ff    <= 1'b0;
         fall_ff       <= 1'b0;
         active_ff     <= 1'b0;
         start_ff      <= '0;
         last_rise_ff  <= '0;
         period_ff     <= '0;
         fired_ff      <= 1'b0;
      end else begin
         tick_count_ff <= tick_count_in;
         waiting_ff    <= waiting_in;
         rise_time_ff  <= rise_time_in;
         width_ff      <= width_in;
         prev_ff       <= prev_in;
         pending_ff    <= pending_in;
         fall_ff       <= fall_in;
         active_ff     <= active_in;
         start_ff      <= start_in;
         last_rise_ff  <= last_rise_in;
         period_ff     <= period_in;
         fired_ff      <= fired_in;
      end
   end

   assign mark.fired = fired_ff;
   assign mark.level = active_ff;

   if (TIME_WIDTH > PERIOD_W) begin : g_wide
      assign mark.period     = period_ff[PERIOD_W-1:0];
      assign mark.period_big = |period_ff[TIME_WIDTH-1:PERIOD_W];
   end else begin : g_narrow
      assign mark.period     = PERIOD_W'(period_ff);
      assign mark.period_big = 1'b0;
   end

endmodule

`default_nettype wire

@@ rtl/core/srfm_divider.sv @@
// ----------------------------------------------------------------------------
// srfm_divider
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module srfm_divider (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire srfm_pkg::div_req_type          req,
   output logic                                busy,
   output logic [srfm_pkg::NUM_W-1:0]          quotient
);
   import srfm_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);

   logic                busy_ff, busy_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [NUM_W-1:0]    rem_ff, rem_in;
   logic [NUM_W-1:0]    shift_ff, shift_in;
   logic [PERIOD_W-1:0] divisor_ff, divisor_in;
   logic                big_ff, big_in;

   logic [NUM_W:0]      trial;
   logic [PERIOD_W-1:0] diff;
   logic                take;

   // remainder never exceeds the numerator prefix, so it stays NUM_W wide
   assign trial = {rem_ff, shift_ff[NUM_W-1]};
   assign take  = !big_ff && (PERIOD_W'(trial) >= divisor_ff);
   assign diff  = PERIOD_W'(trial) - divisor_ff;

   always_comb begin
      busy_in    = busy_ff;
      count_in   = count_ff;
      rem_in     = rem_ff;
      shift_in   = shift_ff;
      divisor_in = divisor_ff;
      big_in     = big_ff;
      if (req.start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         shift_in   = req.numerator;
         divisor_in = req.divisor;
         big_in     = req.divisor_big;
      end else if (busy_ff) begin
         rem_in   = take ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
         shift_in = {shift_ff[NUM_W-2:0], take};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      shift_ff   <= shift_in;
      divisor_ff <= divisor_in;
      big_ff     <= big_in;
   end

   assign busy     = busy_ff;
   assign quotient = shift_ff;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the pulse ratio marker detector and frequency meter
// ----------------------------------------------------------------------------
// Sends one tick per req transaction and follows every tick with its own
// cycle-free model of the detector: rise stamp, fall width, ratio test,
// marker firing, output stretch and millihertz frequency. The bench starts
// with a hand-built pulse train, then runs phases of random pulse trains.
// Each phase writes both registers, with the extremes among them. Both sides
// of the stream idle at random, and one phase runs with no idling at all.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import srfm_pkg::*;

   // a watchdog ends the run after this many cycles with no transaction
   localparam int STALL_LIMIT = 2000;
   // settle time at the end, longer than a marker tick with its divider
   localparam int SETTLE_CYCLES = 40;

   // one result transaction, split into its fields
   typedef struct packed {
      bit        out_level;
      bit        marker_seen;
      bit [31:0] marker_period;
      bit [29:0] frequency_mhz;
      bit        period_zero;
   } tick_result_type;

   // ------------------------------------------------------------------------
   // scoreboard: mirrors the detector tick by tick and holds the results
   // that are still owed by the block, oldest first
   // ------------------------------------------------------------------------
   class marker_scoreboard;
      bit [15:0]    stretch_ticks;
      bit [19:0]    tick_rate;

      bit [31:0]    tick_count;
      bit           waiting_for_rise;
      bit [31:0]    rise_time;
      bit [31:0]    current_width;
      bit [31:0]    previous_width;
      bit           ratio_pending;
      bit           stretch_active;
      bit [31:0]    stretch_start;
      bit [31:0]    last_marker_rise;

      tick_result_type owed_results[$];
      int              fails;

      function new();
         stretch_ticks    = STRETCH_RESET;
         tick_rate        = TPS_RESET;
         tick_count       = '0;
         waiting_for_rise = 1'b1;
         rise_time        = '0;
         current_width    = '0;
         previous_width   = PREV_RESET[31:0];
         ratio_pending    = 1'b0;
         stretch_active   = 1'b0;
         stretch_start    = '0;
         last_marker_rise = '0;
         fails            = 0;
      endfunction

      function void set_reg(logic idx, bit [31:0] value);
         if (idx == REG_STRETCH) begin
            stretch_ticks = value[15:0];
         end else begin
            tick_rate = value[19:0];
         end
      endfunction

      // one accepted tick: rise, fall, marker, release, in that order
      function void note_tick(bit level);
         bit [31:0]       now;
         bit [31:0]       period;
         bit [31:0]       held_for;
         bit [63:0]       quotient;
         tick_result_type r;
         now = tick_count;
         r   = '0;
         if (level && waiting_for_rise) begin
            rise_time        = now;
            waiting_for_rise = 1'b0;
         end
         if (!level && !waiting_for_rise) begin
            current_width    = now - rise_time;
            waiting_for_rise = 1'b1;
            // every fall overwrites the pending mark, zero divisor counts as a mark
            if (previous_width == 0) begin
               ratio_pending = 1'b1;
            end else begin
               ratio_pending = (current_width / previous_width) >= 2;
            end
            previous_width = current_width;
         end
         if (ratio_pending && !stretch_active) begin
            stretch_active   = 1'b1;
            stretch_start    = now;
            ratio_pending    = 1'b0;
            previous_width   = current_width;
            period           = rise_time - last_marker_rise;
            last_marker_rise = rise_time;
            r.marker_seen    = 1'b1;
            r.marker_period  = period;
            if (period == 0) begin
               r.frequency_mhz = FREQ_MAX;
               r.period_zero   = 1'b1;
            end else begin
               quotient = (64'(tick_rate) * 64'(FREQ_SCALE)) / 64'(period);
               if (quotient > 64'(FREQ_MAX)) begin
                  quotient = 64'(FREQ_MAX);
               end
               r.frequency_mhz = quotient[29:0];
            end
         end
         // strict greater-than release, so a zero stretch drops on the next tick
         held_for = now - stretch_start;
         if (stretch_active && held_for > 32'(stretch_ticks)) begin
            stretch_active = 1'b0;
         end
         tick_count  = tick_count + 1;
         r.out_level = stretch_active;
         owed_results.push_back(r);
      endfunction

      function void compare_field(string name, bit [31:0] want, bit [31:0] got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            fails++;
         end
      endfunction

      function void check_result(tick_result_type got);
         tick_result_type want;
         if (owed_results.size() == 0) begin
            $display("%0t: result with nothing owed, actual %0h", $time, got);
            fails++;
            return;
         end
         want = owed_results.pop_front();
         compare_field("out_level", want.out_level, got.out_level);
         compare_field("marker_seen", want.marker_seen, got.marker_seen);
         compare_field("marker_period", want.marker_period, got.marker_period);
         compare_field("frequency_mhz", want.frequency_mhz, got.frequency_mhz);
         compare_field("period_zero", want.period_zero, got.period_zero);
      endfunction

      function int owed();
         return owed_results.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // block under test and its stimulus signals, all known from time zero
   // ------------------------------------------------------------------------
   logic        clock;
   logic        reset        = 1'b1;

   logic        req_tvalid   = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata    = '0;    // [0] signal_level, [7:1] zero

   logic        rsp_tvalid;
   logic        rsp_tready   = 1'b0;
   logic [63:0] rsp_tdata;            // [0] out_level, [32:1] marker_period,
                                      // [62:33] frequency_mhz, [63] period_zero
   logic        rsp_tuser;            // [0] marker_seen

   logic        csr_psel     = 1'b0;
   logic        csr_penable  = 1'b0;
   logic        csr_pwrite   = 1'b0;
   logic [2:0]  csr_paddr    = '0;
   logic [31:0] csr_pwdata   = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sync_pulse_ratio_frequency_meter uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   marker_scoreboard board = new();

   // percent of ticks after a gap (req) or of rsp cycles that start a stall
   int              tick_gap_pct  = 0;
   int              rsp_stall_pct = 0;
   int              stall_left    = 0;
   int              quiet_cycles  = 0;
   tick_result_type seen_result;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // idle length: mostly none or short, now and then a long one
   function automatic int pick_idle(int pct);
      if (pct == 0 || $urandom_range(99) >= pct) begin
         return 0;
      end
      if ($urandom_range(9) == 0) begin
         return $urandom_range(20, 60);
      end
      return $urandom_range(1, 3);
   endfunction

   // ------------------------------------------------------------------------
   // result side: check every accepted transaction, stall at random
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_result.out_level     = rsp_tdata[0];
            seen_result.marker_seen   = rsp_tuser;
            seen_result.marker_period = rsp_tdata[32:1];
            seen_result.frequency_mhz = rsp_tdata[62:33];
            seen_result.period_zero   = rsp_tdata[63];
            board.check_result(seen_result);
         end
         if (stall_left == 0) begin
            stall_left = pick_idle(rsp_stall_pct);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog: any transaction on any port resets the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------

   // one tick transaction; valid stays high afterwards unless a gap follows
   task automatic send_tick(input bit level);
      int gap;
      gap = pick_idle(tick_gap_pct);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, level};
      do @(posedge clock); while (!req_tready);
      board.note_tick(level);
   endtask

   // stop sending and wait until every owed result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.owed() != 0) @(posedge clock);
   endtask

   // both registers back to back, setup then access for each
   task automatic write_regs(input bit [31:0] stretch, input bit [31:0] rate);
      logic        idx   [2];
      logic [31:0] value [2];
      idx[0]   = REG_STRETCH;
      idx[1]   = REG_TPS;
      value[0] = stretch;
      value[1] = rate;
      for (int i = 0; i < 2; i++) begin
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= {idx[i], 2'b00};
         csr_pwdata  <= value[i];
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         board.set_reg(idx[i], value[i]);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // random pulse trains: mostly whole pulses whose widths jump up and down
   // so the ratio test fires often, the rest short runs of random-level noise ticks
   task automatic run_pulses(input int n_ticks);
      int sent;
      int high_len;
      int low_len;
      int pick;
      sent = 0;
      while (sent < n_ticks) begin
         pick = $urandom_range(99);
         if (pick < 85) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
               high_len = $urandom_range(1, 3);
            end else if (pick < 85) begin
               high_len = $urandom_range(4, 16);
            end else begin
               high_len = $urandom_range(17, 40);
            end
            low_len = ($urandom_range(7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
            repeat (high_len) send_tick(1'b1);
            repeat (low_len) send_tick(1'b0);
            sent += high_len + low_len;
         end else begin
            low_len = $urandom_range(1, 5);
            repeat (low_len) send_tick(1'($urandom_range(1)));
            sent += low_len;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin : main_sequence
      // hand-built train at reset settings: a short pulse, a wider one that
      // fires a marker, a pulse that goes pending under the stretch, then a
      // narrow pulse that clears the waiting mark before release
      bit          opening_levels [25] = '{0, 0, 1, 0, 1, 1, 1, 0, 1, 0, 1, 1, 1,
                                           1, 1, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0};
      bit [31:0]   phase_stretch  [6];
      bit [31:0]   phase_rate     [6];
      int          phase_ticks    [6];
      int          phase_gap      [6];

      // reset values, zero stretch and tick rate with no idling, values of one,
      // largest nominal rate with longest stretch, all-ones rate, random mix
      phase_stretch = '{10, 0, 1, 65535, $urandom_range(2, 30), $urandom_range(0, 8)};
      phase_rate    = '{1000, 0, 1, 1000000, 20'hFFFFF, $urandom_range(1, 1000000)};
      phase_ticks   = '{320, 320, 320, 220, 320, 380};
      phase_gap     = '{30, 0, 50, 20, 30, 40};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      tick_gap_pct  = 25;
      rsp_stall_pct = 25;
      foreach (opening_levels[i]) send_tick(opening_levels[i]);

      for (int p = 0; p < 6; p++) begin
         drain();
         write_regs(phase_stretch[p], phase_rate[p]);
         tick_gap_pct  = phase_gap[p];
         rsp_stall_pct = phase_gap[p];
         run_pulses(phase_ticks[p]);
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.fails == 0 && board.owed() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
